/* sv/gds_pkg.sv */
// gds_pkg: shared types, codes and table helpers for the Gaussian density of states block.
// Depends on nothing; used by gds_kern, the top level and gds_chk.
`default_nettype none
package gds_pkg;

	localparam int MAX_FREQS         = 1024;
	localparam int EXP_TABLE_ENTRIES = 256;
	localparam int ARG_BITS          = 20;
	localparam logic [47:0] DENS_MAX = 48'hFFFF_FFFF_FFFF;

	// request codes
	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_QUERY  = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// register indexes
	localparam logic [1:0] CFG_MIN_FREQ  = 2'd0;
	localparam logic [1:0] CFG_FREQ_STEP = 2'd1;
	localparam logic [1:0] CFG_INV_SIGMA = 2'd2;
	localparam logic [1:0] CFG_NORM      = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] freq_value;
		logic [15:0]        grid_index;
	} req_t;

	typedef struct packed {
		logic signed [31:0] grid_freq;
		logic [47:0]        density;
	} rsp_t;

	// kernel pipeline status toward the sequencer
	typedef struct packed {
		logic        vld;
		logic        busy;
		logic [32:0] term;
	} kern_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GRID,
		ST_WSUM,
		ST_RUN,
		ST_DRAIN,
		ST_SCALE,
		ST_FIN
	} state_t;

	// per-step decay factor exp(-t), 20-term Taylor series, Q0.32
	function automatic logic [63:0] exp_base(input logic [63:0] t);
		logic [63:0] term;
		logic [63:0] base;
		term = 64'd1 << 32;
		base = 64'd1 << 32;
		for (int n = 1; n <= 20; n++) begin
			term = ((term * t) >> 32) / 64'(n);
			if ((n & 1) == 1) begin
				base = base - term;
			end else begin
				base = base + term;
			end
		end
		return base;
	endfunction

	// table entry k: repeated rounded multiply by the decay factor
	function automatic logic [32:0] exp_entry(input logic [63:0] base, input int k);
		logic [63:0] v;
		v = 64'd1 << 32;
		for (int i = 1; i <= k; i++) begin
			v = (v * base + 64'h8000_0000) >> 32;
		end
		return v[32:0];
	endfunction

endpackage
`default_nettype wire

/* sv/gds_ram.sv */
// gds_ram: generic single write port RAM with registered read.
// No dependencies.
`default_nettype none
module gds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* sv/gds_kern.sv */
// gds_kern: pipelined Gaussian kernel, one stored frequency per cycle.
// Depends on gds_pkg (kern_out_t, table helpers).
`default_nettype none
module gds_kern #(
	parameter int EXP_TABLE_ENTRIES = gds_pkg::EXP_TABLE_ENTRIES
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_vld,
	input  wire logic signed [31:0] w,
	input  wire logic signed [31:0] f,
	input  wire logic        [31:0] inv_sigma_sq,
	output gds_pkg::kern_out_t      kout
);

	localparam int IW = $clog2(EXP_TABLE_ENTRIES);
	localparam int PW = gds_pkg::ARG_BITS + IW + 1;
	localparam logic [63:0] TSTEP = (64'd1 << 36) / 64'(EXP_TABLE_ENTRIES);
	localparam logic [63:0] BASE  = gds_pkg::exp_base(TSTEP);
	localparam logic [32:0] ARG_LIMIT = 33'd1 << gds_pkg::ARG_BITS;

	logic [32:0] tbl [EXP_TABLE_ENTRIES];

	for (genvar g = 0; g < EXP_TABLE_ENTRIES; g++) begin : g_tbl
		assign tbl[g] = gds_pkg::exp_entry(BASE, g);
	end

	logic        v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;
	logic [31:0] mag_s2;
	logic [63:0] sq_s3;
	logic        ovf_s4;
	logic [19:0] hi_s4;
	logic [31:0] lo_s4;
	logic        ok_s5;
	logic [IW-1:0] idx_s5;
	logic [32:0] term_s6;

	logic signed [32:0] diff;
	logic [32:0] mag;
	logic [63:0] hi_prod;
	logic [63:0] lo_prod;
	logic [32:0] arg;
	logic [PW-1:0] idx_prod;

	// datapath per stage
	always_comb begin
		diff     = 33'(w) - 33'(f);
		mag      = diff[32] ? 33'(-diff) : 33'(diff);
		hi_prod  = 64'(sq_s3[63:32]) * 64'(inv_sigma_sq);
		lo_prod  = 64'(sq_s3[31:0]) * 64'(inv_sigma_sq);
		arg      = 33'(hi_s4) + 33'(lo_s4);
		idx_prod = PW'(arg[19:0]) * PW'(EXP_TABLE_ENTRIES);
	end

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
		end else begin
			v2_s2 <= in_vld;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			v5_s5 <= v4_s4;
			v6_s6 <= v5_s5;
		end
	end

	// payload pipe: |w-f|, square, scale by 1/sigma^2, table index, lookup
	always_ff @(posedge clk) begin
		mag_s2  <= mag[31:0];
		sq_s3   <= 64'(mag_s2) * 64'(mag_s2);
		ovf_s4  <= |hi_prod[63:20];
		hi_s4   <= hi_prod[19:0];
		lo_s4   <= lo_prod[63:32];
		ok_s5   <= !ovf_s4 && (arg < ARG_LIMIT);
		idx_s5  <= idx_prod[gds_pkg::ARG_BITS +: IW];
		term_s6 <= ok_s5 ? tbl[idx_s5] : 33'd0;
	end

	assign kout.vld  = v6_s6;
	assign kout.busy = v2_s2 | v3_s3 | v4_s4 | v5_s5 | v6_s6;
	assign kout.term = term_s6;

endmodule
`default_nettype wire

/* sv/gaussian_density_of_states.sv */
// gaussian_density_of_states: top level, sequencer, config registers and frequency store.
// Depends on gds_pkg, gds_ram, gds_kern.
//
//  channel   signals                             direction  payload
//  request   req_valid / req_stall / req_data    in         gds_pkg::req_t
//  response  rsp_valid / rsp_stall / rsp_data    out        gds_pkg::rsp_t
//  config    cfg_we / cfg_index / cfg_data       in         48-bit write
//
// Load and clear requests finish on acceptance and never stall the request channel.
// A query keeps the block busy from acceptance until its response is loaded: grid
// setup, one stored frequency per cycle through the kernel pipeline, pipeline drain and
// four partial products of the final scale on one shared 32x32 multiplier.
// Reset empties the store and loads the register defaults; the store needs no clearing.
// A finished response waits in its output register; a stalled response holds.
`default_nettype none
module gaussian_density_of_states #(
	parameter int MAX_FREQS         = gds_pkg::MAX_FREQS,
	parameter int EXP_TABLE_ENTRIES = gds_pkg::EXP_TABLE_ENTRIES
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire gds_pkg::req_t req_data,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output gds_pkg::rsp_t      rsp_data,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [47:0]   cfg_data
);

	localparam int AW = $clog2(MAX_FREQS);
	localparam int CW = $clog2(MAX_FREQS + 1);
	localparam int SW = 33 + CW;

	gds_pkg::state_t state_q, state_d;

	logic signed [31:0] min_freq_q;
	logic [30:0]        freq_step_q;
	logic [31:0]        inv_sigma_q;
	logic [47:0]        norm_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic          rd_vld_s1;
	logic [15:0]   gi_q;
	logic [46:0]   wprod_q;
	logic signed [31:0] w_q;
	logic [SW-1:0] sum_q;
	logic [2:0]    sc_q;
	logic [63:0]   mul_q;
	logic [1:0]    sh_q;
	logic [111:0]  acc_q;
	logic          rsp_valid_q;
	gds_pkg::rsp_t rsp_q;

	logic accept;
	logic issue;
	logic ram_we;
	logic rsp_load;
	logic [31:0] ram_rdata;
	gds_pkg::kern_out_t kout;

	logic signed [48:0] wsum;
	logic signed [31:0] wsat;
	logic [63:0] a_op, b_op;
	logic [31:0] a_part, b_part;
	logic [111:0] acc_add;
	logic [47:0] dens;

	assign accept    = req_valid && (state_q == gds_pkg::ST_IDLE);
	assign req_stall = (state_q != gds_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gds_pkg::ST_IDLE: begin
				if (accept && req_data.req_type == gds_pkg::REQ_QUERY) begin
					state_d = gds_pkg::ST_GRID;
				end
			end
			gds_pkg::ST_GRID: state_d = gds_pkg::ST_WSUM;
			gds_pkg::ST_WSUM: state_d = gds_pkg::ST_RUN;
			gds_pkg::ST_RUN: begin
				if (rd_idx_q == count_q) begin
					state_d = gds_pkg::ST_DRAIN;
				end
			end
			gds_pkg::ST_DRAIN: begin
				if (!rd_vld_s1 && !kout.busy) begin
					state_d = gds_pkg::ST_SCALE;
				end
			end
			gds_pkg::ST_SCALE: begin
				if (sc_q == 3'd4) begin
					state_d = gds_pkg::ST_FIN;
				end
			end
			gds_pkg::ST_FIN: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = gds_pkg::ST_IDLE;
				end
			end
			default: state_d = gds_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ram_we   = 1'b0;
		issue    = 1'b0;
		rsp_load = 1'b0;
		case (state_q)
			gds_pkg::ST_IDLE: begin
				ram_we = accept && req_data.req_type == gds_pkg::REQ_LOAD
					&& count_q < CW'(MAX_FREQS);
			end
			gds_pkg::ST_RUN:  issue = (rd_idx_q != count_q);
			gds_pkg::ST_FIN:  rsp_load = !rsp_valid_q || !rsp_stall;
			default: ;
		endcase
	end

	// grid point, saturated to 32 bits signed
	always_comb begin
		wsum = 49'(min_freq_q) + $signed({2'b00, wprod_q});
		if (wsum > 49'sd2147483647) begin
			wsat = 32'sh7FFF_FFFF;
		end else if (wsum < -49'sd2147483648) begin
			wsat = 32'sh8000_0000;
		end else begin
			wsat = wsum[31:0];
		end
	end

	// final scale operands and accumulation
	always_comb begin
		a_op    = 64'(sum_q);
		b_op    = 64'(norm_q);
		a_part  = sc_q[1] ? a_op[63:32] : a_op[31:0];
		b_part  = sc_q[0] ? b_op[63:32] : b_op[31:0];
		acc_add = {48'd0, mul_q} << {sh_q, 5'd0};
		dens    = (acc_q[111:32] > 80'(gds_pkg::DENS_MAX)) ? gds_pkg::DENS_MAX
			: acc_q[79:32];
	end

	gds_ram #(
		.WIDTH(32),
		.DEPTH(MAX_FREQS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(req_data.freq_value),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	gds_kern #(
		.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
	) u_kern (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (rd_vld_s1),
		.w           (w_q),
		.f           (ram_rdata),
		.inv_sigma_sq(inv_sigma_q),
		.kout        (kout)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gds_pkg::ST_IDLE;
			min_freq_q  <= '0;
			freq_step_q <= 31'd65536;
			inv_sigma_q <= 32'd65536;
			norm_q      <= 48'h1_0000_0000;
			count_q     <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			sc_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (cfg_we) begin
				case (cfg_index)
					gds_pkg::CFG_MIN_FREQ:  min_freq_q  <= cfg_data[31:0];
					gds_pkg::CFG_FREQ_STEP: freq_step_q <= cfg_data[30:0];
					gds_pkg::CFG_INV_SIGMA: inv_sigma_q <= cfg_data[31:0];
					gds_pkg::CFG_NORM:      norm_q      <= cfg_data;
					default: ;
				endcase
			end
			if (ram_we) begin
				count_q <= count_q + CW'(1);
			end else if (accept && req_data.req_type == gds_pkg::REQ_CLEAR) begin
				count_q <= '0;
			end
			if (state_q == gds_pkg::ST_WSUM) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (state_q == gds_pkg::ST_SCALE) begin
				sc_q <= sc_q + 1'b1;
			end else begin
				sc_q <= '0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			gi_q <= req_data.grid_index;
		end
		wprod_q <= 47'(gi_q) * 47'(freq_step_q);
		if (state_q == gds_pkg::ST_WSUM) begin
			w_q   <= wsat;
			sum_q <= '0;
		end else if (kout.vld) begin
			sum_q <= sum_q + SW'(kout.term);
		end
		// one partial product per cycle, registered and added in the next cycle
		mul_q <= 64'(a_part) * 64'(b_part);
		sh_q  <= 2'(sc_q[1]) + 2'(sc_q[0]);
		// product held through a stalled finish
		if (state_q == gds_pkg::ST_WSUM) begin
			acc_q <= '0;
		end else if (state_q == gds_pkg::ST_SCALE && sc_q != 3'd0) begin
			acc_q <= acc_q + acc_add;
		end
		if (rsp_load) begin
			rsp_q.grid_freq <= w_q;
			rsp_q.density   <= dens;
		end
	end

endmodule
`default_nettype wire

/* sv/gds_chk.sv */
// gds_chk: port-level checker for gaussian_density_of_states, bound to the top level.
// Depends on gds_pkg (request codes, payload types).
`default_nettype none
module gds_chk (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire gds_pkg::req_t req_data,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire gds_pkg::rsp_t rsp_data
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response changed");

	// an accepted query makes the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_data.req_type == gds_pkg::REQ_QUERY |=> req_stall)
		else $error("query did not occupy the block");

	// loads, clears and unused request codes finish at once
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_data.req_type != gds_pkg::REQ_QUERY |=> !req_stall)
		else $error("non-query request blocked the block");

	// a response appears only at the end of a query
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response without a query in progress");

endmodule

bind gaussian_density_of_states gds_chk u_gds_chk (.*);
`default_nettype wire
